// File: src/next_fit_id_slot_table_core_defines.svh
// Assertion macros used by the slot table datapath.
`ifndef NEXT_FIT_ID_SLOT_TABLE_CORE_DEFINES_SVH
`define NEXT_FIT_ID_SLOT_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define NFIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");
`define NFIT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");
`else
`define NFIT_ASSERT_IMP(lbl, ante, cons)
`define NFIT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/nfit_pkg.sv
package nfit_pkg;

    localparam int DEFAULT_SLOTS = 256;
    localparam int DATA_W        = 32;
    localparam int USER_W        = 2;
    localparam int ID_W          = 12;
    localparam int OWNER_W       = 16;
    localparam int STATUS_W      = 3;
    localparam int GID_W         = 9;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SAME     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_EVAL,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_item;
        logic scan_init;
        logic scan_step;
        logic eval_item;
        logic push_out;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic scan_req;
        logic scan_hit;
        logic scan_full;
        logic out_free;
    } stat_t;

endpackage

// File: src/nfit_ram.sv
module nfit_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/nfit_ctrl.sv
module nfit_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  nfit_pkg::stat_t stat,
    output nfit_pkg::ctl_t  ctl
);

    nfit_pkg::state_t state_reg;
    nfit_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfit_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            nfit_pkg::S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = nfit_pkg::S_IDLE;
                end
            end
            nfit_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = nfit_pkg::S_DECODE;
                end
            end
            nfit_pkg::S_DECODE:
            begin
                if (stat.scan_req)
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = nfit_pkg::S_SCAN;
                end
                else
                begin
                    ctl.rd_item = 1'b1;
                    state_next  = nfit_pkg::S_EVAL;
                end
            end
            nfit_pkg::S_EVAL:
            begin
                ctl.eval_item = 1'b1;
                state_next    = nfit_pkg::S_RESP;
            end
            nfit_pkg::S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_hit || stat.scan_full)
                begin
                    state_next = nfit_pkg::S_RESP;
                end
            end
            nfit_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.push_out = 1'b1;
                    state_next   = nfit_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfit_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/nfit_dp.sv
`include "next_fit_id_slot_table_core_defines.svh"

module nfit_dp #(
    parameter int SLOTS = nfit_pkg::DEFAULT_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nfit_pkg::ctl_t              ctl,
    output nfit_pkg::stat_t             stat,
    input  logic [nfit_pkg::DATA_W-1:0] s_tdata,
    input  logic [nfit_pkg::USER_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nfit_pkg::DATA_W-1:0] m_tdata
);

    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int OW    = nfit_pkg::OWNER_W;
    localparam int RW    = OW + 1;
    localparam int IDW   = nfit_pkg::ID_W;
    localparam int GW    = nfit_pkg::GID_W;
    localparam int SW    = nfit_pkg::STATUS_W;
    localparam int PAD_W = nfit_pkg::DATA_W - SW - GW - OW;

    localparam logic [IW-1:0]  LAST     = IW'(SLOTS - 1);
    localparam logic [CW-1:0]  COUNT    = CW'(SLOTS);
    localparam logic [IDW:0]   SLOTS_ID = (IDW + 1)'(SLOTS);

    nfit_pkg::op_t       op_reg;
    logic [IDW-1:0]      id_reg;
    logic [OW-1:0]       owner_reg;

    logic [IW-1:0]       cursor_reg;
    logic [IW-1:0]       clr_addr_reg;
    logic [IW-1:0]       scan_addr_reg;
    logic [IW-1:0]       chk_addr_reg;
    logic [CW-1:0]       issued_reg;
    logic                chk_valid_reg;

    logic [SW-1:0]       res_status_reg;
    logic [GW-1:0]       res_gid_reg;
    logic [OW-1:0]       res_owner_reg;
    logic [SW-1:0]       out_status_reg;
    logic [GW-1:0]       out_gid_reg;
    logic [OW-1:0]       out_owner_reg;
    logic                m_tvalid_reg;

    logic                usable;
    logic [IW-1:0]       item_idx;
    logic [IW-1:0]       scan_addr_next;
    logic [IW-1:0]       chk_addr_next;
    logic                scan_hit;
    logic                scan_full;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [RW-1:0]       wr_data;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic [RW-1:0]       rd_data;

    assign usable         = (id_reg != '0) && ({1'b0, id_reg} <= SLOTS_ID);
    assign item_idx       = IW'(id_reg - IDW'(1));
    assign scan_addr_next = (scan_addr_reg == LAST) ? '0 : scan_addr_reg + IW'(1);
    assign chk_addr_next  = (chk_addr_reg == LAST) ? '0 : chk_addr_reg + IW'(1);
    assign scan_hit       = chk_valid_reg && !rd_data[RW-1];
    assign scan_full      = (issued_reg == COUNT) && !chk_valid_reg;

    assign stat.clr_last  = (clr_addr_reg == LAST);
    assign stat.scan_req  = (op_reg == nfit_pkg::OP_ALLOC) && !usable;
    assign stat.scan_hit  = scan_hit;
    assign stat.scan_full = scan_full;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = item_idx;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = item_idx;
        if (ctl.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
        end
        if (ctl.rd_item)
        begin
            rd_en = 1'b1;
        end
        if (ctl.scan_step)
        begin
            if (issued_reg != COUNT)
            begin
                rd_en   = 1'b1;
                rd_addr = scan_addr_reg;
            end
            if (scan_hit)
            begin
                wr_en   = 1'b1;
                wr_addr = chk_addr_reg;
                wr_data = {1'b1, owner_reg};
            end
        end
        if (ctl.eval_item && (op_reg == nfit_pkg::OP_RELEASE) && usable)
        begin
            wr_en = 1'b1;
        end
    end

    nfit_ram #(
        .WIDTH(RW),
        .DEPTH(SLOTS)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            clr_addr_reg  <= '0;
            issued_reg    <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + IW'(1);
            end
            if (ctl.scan_init)
            begin
                issued_reg    <= '0;
                chk_valid_reg <= 1'b0;
            end
            if (ctl.scan_step)
            begin
                if (issued_reg != COUNT)
                begin
                    issued_reg    <= issued_reg + CW'(1);
                    chk_valid_reg <= 1'b1;
                end
                else
                begin
                    chk_valid_reg <= 1'b0;
                end
                if (scan_hit)
                begin
                    cursor_reg <= chk_addr_next;
                end
            end
            if (ctl.push_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= nfit_pkg::op_t'(s_tuser);
            id_reg    <= s_tdata[IDW-1:0];
            owner_reg <= s_tdata[IDW+OW-1:IDW];
        end
        if (ctl.scan_init)
        begin
            scan_addr_reg <= cursor_reg;
        end
        if (ctl.scan_step)
        begin
            if (issued_reg != COUNT)
            begin
                scan_addr_reg <= scan_addr_next;
                chk_addr_reg  <= scan_addr_reg;
            end
            if (scan_hit)
            begin
                res_status_reg <= nfit_pkg::ST_OK;
                res_gid_reg    <= GW'({1'b0, chk_addr_reg} + (IW + 1)'(1));
                res_owner_reg  <= '0;
            end
            else if (scan_full)
            begin
                res_status_reg <= nfit_pkg::ST_FULL;
                res_gid_reg    <= '0;
                res_owner_reg  <= '0;
            end
        end
        if (ctl.eval_item)
        begin
            res_gid_reg    <= GW'(id_reg);
            res_owner_reg  <= '0;
            res_status_reg <= nfit_pkg::ST_NOTFOUND;
            case (op_reg)
                nfit_pkg::OP_ALLOC:
                begin
                    if (rd_data[RW-1] && (rd_data[OW-1:0] == owner_reg))
                    begin
                        res_status_reg <= nfit_pkg::ST_SAME;
                    end
                    else
                    begin
                        res_status_reg <= nfit_pkg::ST_MISMATCH;
                    end
                end
                nfit_pkg::OP_RELEASE:
                begin
                    if (usable)
                    begin
                        res_status_reg <= nfit_pkg::ST_OK;
                    end
                end
                nfit_pkg::OP_LOOKUP:
                begin
                    if (usable && rd_data[RW-1])
                    begin
                        res_status_reg <= nfit_pkg::ST_OK;
                        res_owner_reg  <= rd_data[OW-1:0];
                    end
                end
                default:
                begin
                    res_gid_reg <= '0;
                end
            endcase
        end
        if (ctl.push_out)
        begin
            out_status_reg <= res_status_reg;
            out_gid_reg    <= res_gid_reg;
            out_owner_reg  <= res_owner_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_owner_reg, out_gid_reg, out_status_reg};

    `NFIT_ASSERT_IMP(a_chk_after_issue, chk_valid_reg, issued_reg != '0)
    `NFIT_ASSERT_NXT(a_push_shows_beat, ctl.push_out, m_tvalid_reg)
    `NFIT_ASSERT_IMP(a_full_gives_zero, m_tvalid_reg && (out_status_reg == nfit_pkg::ST_FULL), out_gid_reg == '0)
    `NFIT_ASSERT_IMP(a_cursor_range, 1'b1, cursor_reg <= LAST)
    `NFIT_ASSERT_IMP(a_status_range, m_tvalid_reg, out_status_reg <= nfit_pkg::ST_NOTFOUND)

endmodule

// File: src/next_fit_id_slot_table_core.sv
// Flow: release, lookup, rebind and unknown commands pass from acceptance through decode and
// evaluate to the response state; an allocate scan probes slots from the cursor until a free one
// is found or all SLOTS have been probed. One slot is probed per cycle through the store's read port.
// Throughput: one item at a time; the next beat is taken once the result is in the output register.
// Reset: asynchronous; afterwards a clearing pass writes every slot empty before any beat is taken.
module next_fit_id_slot_table_core #(
    parameter int SLOTS = nfit_pkg::DEFAULT_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // slot_id [11:0], owner [27:12], zero [31:28]
    input  logic [nfit_pkg::DATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  logic [nfit_pkg::USER_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status [2:0], granted_id [11:3], found_owner [27:12], zero [31:28]
    output logic [nfit_pkg::DATA_W-1:0] m_tdata
);

    nfit_pkg::ctl_t  ctl;
    nfit_pkg::stat_t stat;

    nfit_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .ctl     (ctl)
    );

    nfit_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
